[hw/rtl/bfd_pkg.sv]
// ----------------------------------------------------------------------------
// bfd_pkg: shared types and constants for the bounded drop-policy FIFO
// Opcodes, status codes, register indexes, stream field widths and the
// command and status groups between the controller and the datapath.
// ----------------------------------------------------------------------------
package bfd_pkg;

	localparam int DEPTH_DEF        = 1024;
	localparam int HANDLE_WIDTH_DEF = 32;
	localparam int MAX_BATCH_DEF    = 16;

	localparam int OP_W     = 3;
	localparam int HDL_W    = HANDLE_WIDTH_DEF;
	localparam int LIMIT_W  = 5;
	localparam int STAT_W   = 3;
	localparam int OCC_W    = 11;
	localparam int TOT_W    = 32;
	localparam int CAP_W    = 11;
	localparam int CFG_IX_W = 1;
	localparam int CFG_D_W  = 11;

	localparam int S_FIELDS_W = OP_W + HDL_W + LIMIT_W;
	localparam int S_DATA_W   = ((S_FIELDS_W + 7) / 8) * 8;
	localparam int M_FIELDS_W = STAT_W + 1 + HDL_W + OCC_W + 3 * TOT_W + OCC_W;
	localparam int M_DATA_W   = ((M_FIELDS_W + 7) / 8) * 8;

	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(1024);

	typedef enum logic [OP_W-1:0] {
		OP_ENQ      = 3'd0,
		OP_DEQ_ONE  = 3'd1,
		OP_DEQ_BAT  = 3'd2,
		OP_CLEAR    = 3'd3,
		OP_STOP     = 3'd4,
		OP_RST_STAT = 3'd5
	} op_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK      = 3'd0,
		ST_EVICTED = 3'd1,
		ST_REJECT  = 3'd2,
		ST_STOPPED = 3'd3,
		ST_EMPTY   = 3'd4
	} status_t;

	typedef enum logic [CFG_IX_W-1:0] {
		REG_CAPACITY = 1'd0,
		REG_POLICY   = 1'd1
	} reg_ix_t;

	typedef struct packed {
		logic load;
		logic exec;
		logic pop;
		logic emit;
		logic last;
	} bfd_cmd_t;

	typedef struct packed {
		logic single;
		logic out_free;
	} bfd_stat_t;

endpackage

[hw/rtl/bounded_fifo_with_drop_policy.sv]
// ----------------------------------------------------------------------------
// bounded_fifo_with_drop_policy: bounded event-handle FIFO with drop policy
// Queue of event handles with programmable capacity, evict-oldest or
// reject-newest overflow handling, batch dequeue and wrapping totals.
//
//   Channel  Direction  Content
//   s_*      in         opcode, event_handle, batch_limit
//   m_*      out        status, data_valid, returned_handle, occupancy,
//                       total_in, total_out, total_lost, peak_occupancy; tlast
//   cfg_*    in         capacity_limit (index 0), overflow_policy (index 1)
//
// An enqueue, clear, stop or statistics reset passes through the load and
// execute states. A dequeue streams its entries out one per cycle while the
// output is not stalled, limited by the single read port of the entry store.
// Reset leaves the queue empty with all totals zero; store contents are kept.
// A stalled output holds the sequencer; one result may wait while the next
// transfer in is taken.
// ----------------------------------------------------------------------------
module bounded_fifo_with_drop_policy
	import bfd_pkg::*;
#(
	parameter int DEPTH        = DEPTH_DEF,
	parameter int MAX_BATCH    = MAX_BATCH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IX_W-1:0]  cfg_index,
	input  logic [CFG_D_W-1:0]   cfg_data,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	// opcode, event_handle, batch_limit
	input  logic [S_DATA_W-1:0]  s_tdata,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// status, data_valid, returned_handle, occupancy, total_in, total_out,
	// total_lost, peak_occupancy, zero fill
	output logic [M_DATA_W-1:0]  m_tdata,
	output logic                 m_tlast
);

	localparam int BW = $clog2(MAX_BATCH + 1);

	bfd_cmd_t      cmd;
	bfd_stat_t     stat;
	logic [BW-1:0] batch_n;

	bfd_ctrl #(
		.MAX_BATCH (MAX_BATCH)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.stat     (stat),
		.batch_n  (batch_n),
		.cmd      (cmd)
	);

	bfd_datapath #(
		.DEPTH        (DEPTH),
		.MAX_BATCH    (MAX_BATCH)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cmd       (cmd),
		.stat      (stat),
		.batch_n   (batch_n)
	);

endmodule

[hw/rtl/bfd_ctrl.sv]
// ----------------------------------------------------------------------------
// bfd_ctrl: operation sequencer
// Takes one command at a time, runs single-result operations in one step and
// walks a dequeue run one entry per cycle while the result register drains.
// ----------------------------------------------------------------------------
module bfd_ctrl
	import bfd_pkg::*;
#(
	parameter int MAX_BATCH = MAX_BATCH_DEF,
	localparam int BW = $clog2(MAX_BATCH + 1)
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           s_tvalid,
	output logic           s_tready,
	input  bfd_stat_t      stat,
	input  logic [BW-1:0]  batch_n,
	output bfd_cmd_t       cmd
);

	typedef enum logic [2:0] {
		S_IDLE  = 3'b001,
		S_EXEC  = 3'b010,
		S_DRAIN = 3'b100
	} state_t;

	state_t        state_q, state_nx;
	logic [BW-1:0] rem_q, rem_nx;

	assign s_tready = (state_q == S_IDLE);

	always_comb begin
		state_nx = state_q;
		rem_nx   = rem_q;
		cmd      = '0;
		case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					cmd.load = 1'b1;
					state_nx = S_EXEC;
				end
			end
			S_EXEC: begin
				if (stat.single) begin
					if (stat.out_free) begin
						cmd.exec = 1'b1;
						state_nx = S_IDLE;
					end
				end else begin
					cmd.pop  = 1'b1;
					rem_nx   = batch_n - BW'(1);
					state_nx = S_DRAIN;
				end
			end
			S_DRAIN: begin
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					cmd.last = (rem_q == '0);
					if (rem_q != '0) begin
						cmd.pop = 1'b1;
						rem_nx  = rem_q - BW'(1);
					end else begin
						state_nx = S_IDLE;
					end
				end
			end
			default: begin
				state_nx = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			rem_q   <= '0;
		end else begin
			state_q <= state_nx;
			rem_q   <= rem_nx;
		end
	end

endmodule

[hw/rtl/bfd_datapath.sv]
// ----------------------------------------------------------------------------
// bfd_datapath: entry store, pointers, totals and result register
// Holds the circular entry store, applies operations on command from the
// sequencer and formats each result into the output register.
// ----------------------------------------------------------------------------
module bfd_datapath
	import bfd_pkg::*;
#(
	parameter int DEPTH        = DEPTH_DEF,
	parameter int MAX_BATCH    = MAX_BATCH_DEF,
	localparam int BW = $clog2(MAX_BATCH + 1)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IX_W-1:0]   cfg_index,
	input  logic [CFG_D_W-1:0]    cfg_data,
	input  logic [S_DATA_W-1:0]   s_tdata,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [M_DATA_W-1:0]   m_tdata,
	output logic                  m_tlast,
	input  bfd_cmd_t              cmd,
	output bfd_stat_t             stat,
	output logic [BW-1:0]         batch_n
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	typedef struct packed {
		logic [OCC_W-1:0]  peak;
		logic [TOT_W-1:0]  lost;
		logic [TOT_W-1:0]  outc;
		logic [TOT_W-1:0]  inc;
		logic [OCC_W-1:0]  occ;
		logic [HDL_W-1:0]  handle;
		logic              valid;
		status_t           status;
	} result_t;

	logic [HDL_W-1:0]   store_q [DEPTH];
	logic [HDL_W-1:0]   rdata_q;

	op_t                op_q;
	logic [HDL_W-1:0]   handle_q;
	logic [LIMIT_W-1:0] limit_q;

	logic [PW-1:0]      head_q, head_nx, tail_q, tail_nx;
	logic [CW-1:0]      count_q, count_nx, peak_q, peak_nx;
	logic               stopped_q, stopped_nx;
	logic [TOT_W-1:0]   in_q, in_nx, outc_q, outc_nx, lost_q, lost_nx;
	logic [CAP_W-1:0]   cap_q;
	logic               policy_q;

	result_t            res_q;
	logic               res_valid_q;
	logic               res_last_q;

	logic [CW-1:0]      eff_cap;
	logic [BW-1:0]      lim_clip;
	logic               wr_en;
	status_t            status_nx;

	function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
		return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
	endfunction

	always_comb begin
		if (cap_q == '0 || 32'(cap_q) > 32'(DEPTH)) begin
			eff_cap = CW'(DEPTH);
		end else begin
			eff_cap = CW'(cap_q);
		end
	end

	always_comb begin
		if (32'(limit_q) > 32'(MAX_BATCH)) begin
			lim_clip = BW'(MAX_BATCH);
		end else begin
			lim_clip = BW'(limit_q);
		end
		if (op_q == OP_DEQ_ONE) begin
			batch_n = BW'(1);
		end else if (32'(count_q) < 32'(lim_clip)) begin
			batch_n = BW'(count_q);
		end else begin
			batch_n = lim_clip;
		end
	end

	assign stat.single = !((op_q == OP_DEQ_ONE || op_q == OP_DEQ_BAT) && !stopped_q &&
		count_q != '0 && batch_n != '0);
	assign stat.out_free = !res_valid_q || m_tready;

	always_comb begin
		head_nx    = head_q;
		tail_nx    = tail_q;
		count_nx   = count_q;
		peak_nx    = peak_q;
		stopped_nx = stopped_q;
		in_nx      = in_q;
		outc_nx    = outc_q;
		lost_nx    = lost_q;
		status_nx  = ST_OK;
		wr_en      = 1'b0;
		if (cmd.exec) begin
			case (op_q)
				OP_ENQ: begin
					if (stopped_q) begin
						status_nx = ST_STOPPED;
					end else if (count_q >= eff_cap && policy_q) begin
						lost_nx   = lost_q + TOT_W'(1);
						status_nx = ST_REJECT;
					end else begin
						wr_en   = 1'b1;
						tail_nx = ptr_inc(tail_q);
						in_nx   = in_q + TOT_W'(1);
						if (count_q >= eff_cap) begin
							head_nx   = ptr_inc(head_q);
							lost_nx   = lost_q + TOT_W'(1);
							status_nx = ST_EVICTED;
						end else begin
							count_nx = count_q + CW'(1);
						end
						if (count_nx > peak_q) begin
							peak_nx = count_nx;
						end
					end
				end
				OP_DEQ_ONE, OP_DEQ_BAT: begin
					if (stopped_q) begin
						status_nx = ST_STOPPED;
					end else if (count_q == '0) begin
						status_nx = ST_EMPTY;
					end
				end
				OP_CLEAR: begin
					lost_nx  = lost_q + TOT_W'(count_q);
					count_nx = '0;
					head_nx  = tail_q;
				end
				OP_STOP: begin
					stopped_nx = 1'b1;
				end
				OP_RST_STAT: begin
					in_nx   = '0;
					outc_nx = '0;
					lost_nx = '0;
					peak_nx = '0;
				end
				default: begin
				end
			endcase
		end
		if (cmd.pop) begin
			head_nx  = ptr_inc(head_q);
			count_nx = count_q - CW'(1);
			outc_nx  = outc_q + TOT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			store_q[tail_q] <= handle_q;
		end
		if (cmd.pop) begin
			rdata_q <= store_q[head_q];
		end
		if (cmd.load) begin
			op_q     <= op_t'(s_tdata[OP_W-1:0]);
			handle_q <= s_tdata[OP_W +: HDL_W];
			limit_q  <= s_tdata[OP_W + HDL_W +: LIMIT_W];
		end
		if (cmd.exec) begin
			res_q.status <= status_nx;
			res_q.valid  <= 1'b0;
			res_q.handle <= '0;
			res_q.occ    <= OCC_W'(count_nx);
			res_q.inc    <= in_nx;
			res_q.outc   <= outc_nx;
			res_q.lost   <= lost_nx;
			res_q.peak   <= OCC_W'(peak_nx);
			res_last_q   <= 1'b1;
		end else if (cmd.emit) begin
			res_q.status <= ST_OK;
			res_q.valid  <= 1'b1;
			res_q.handle <= rdata_q;
			res_q.occ    <= OCC_W'(count_q);
			res_q.inc    <= in_q;
			res_q.outc   <= outc_q;
			res_q.lost   <= lost_q;
			res_q.peak   <= OCC_W'(peak_q);
			res_last_q   <= cmd.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			tail_q      <= '0;
			count_q     <= '0;
			peak_q      <= '0;
			stopped_q   <= 1'b0;
			in_q        <= '0;
			outc_q      <= '0;
			lost_q      <= '0;
			cap_q       <= CAP_RESET;
			policy_q    <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			head_q    <= head_nx;
			tail_q    <= tail_nx;
			count_q   <= count_nx;
			peak_q    <= peak_nx;
			stopped_q <= stopped_nx;
			in_q      <= in_nx;
			outc_q    <= outc_nx;
			lost_q    <= lost_nx;
			if (cfg_we) begin
				case (reg_ix_t'(cfg_index))
					REG_CAPACITY: begin
						if (count_q == '0) begin
							cap_q <= cfg_data[CAP_W-1:0];
						end
					end
					REG_POLICY: begin
						policy_q <= cfg_data[0];
					end
					default: begin
					end
				endcase
			end
			if (cmd.exec || cmd.emit) begin
				res_valid_q <= 1'b1;
			end else if (m_tready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = res_valid_q;
	assign m_tlast  = res_last_q;
	assign m_tdata  = {{(M_DATA_W - M_FIELDS_W){1'b0}}, res_q};

endmodule

[sim/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: regression for the bounded drop-policy event-handle FIFO
// Commands stream into the queue while a behavioral copy of the queue predicts
// every status, returned handle, occupancy and total. The run covers a short
// directed set and random phases over several capacity and overflow settings,
// and ends with traffic after a stop. Both stream sides idle and stall at
// random.
// ----------------------------------------------------------------------------
module tb;
	import bfd_pkg::*;

	localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
	localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;
	localparam int PHASES = 6;
	localparam int PHASE_ITEMS = 20;

	typedef struct packed {
		logic [M_DATA_W-M_FIELDS_W-1:0] pad;
		logic [OCC_W-1:0]               peak;
		logic [TOT_W-1:0]               lost;
		logic [TOT_W-1:0]               dequeued;
		logic [TOT_W-1:0]               enqueued;
		logic [OCC_W-1:0]               occ;
		logic [HDL_W-1:0]               handle;
		logic                           valid;
		logic [STAT_W-1:0]              status;
	} fifo_result_t;

	typedef struct {
		fifo_result_t fields;
		logic         last;
	} fifo_expect_t;

	typedef struct {
		logic [OP_W-1:0]    op;
		logic [HDL_W-1:0]   handle;
		logic [LIMIT_W-1:0] limit;
	} fifo_cmd_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                cfg_we = 1'b0;
	logic [CFG_IX_W-1:0] cfg_index = '0;
	logic [CFG_D_W-1:0]  cfg_data = '0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	// opcode, event_handle, batch_limit
	logic [S_DATA_W-1:0] s_tdata = '0;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	// status, data_valid, returned_handle, occupancy, total_in, total_out,
	// total_lost, peak_occupancy, zero fill
	logic [M_DATA_W-1:0] m_tdata;
	logic                m_tlast;

	fifo_cmd_t    pending_cmds[$];
	fifo_expect_t expected_results[$];
	fifo_cmd_t    sent_cmd;
	int           errors = 0;

	logic [HDL_W-1:0] handle_store [DEPTH_DEF];
	int               q_head = 0;
	int               q_tail = 0;
	int               q_count = 0;
	int               q_peak = 0;
	logic             q_stopped = 1'b0;
	logic [TOT_W-1:0] total_enq = '0;
	logic [TOT_W-1:0] total_deq = '0;
	logic [TOT_W-1:0] total_drop = '0;
	int               cap_reg = 1024;
	logic             policy_reg = 1'b0;

	logic in_took = 1'b0;
	logic out_took = 1'b0;
	int   send_gap = 0;
	int   recv_stall = 0;
	logic send_calm = 1'b0;
	logic recv_calm = 1'b0;

	bounded_fifo_with_drop_policy DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic int usable_capacity();
		if (cap_reg == 0 || cap_reg > DEPTH_DEF)
			return DEPTH_DEF;
		return cap_reg;
	endfunction

	function automatic void record_result(logic [STAT_W-1:0] st, logic valid,
			logic [HDL_W-1:0] handle, logic last);
		fifo_expect_t e;
		e.fields = '0;
		e.fields.status = st;
		e.fields.valid = valid;
		e.fields.handle = handle;
		e.fields.occ = OCC_W'(q_count);
		e.fields.enqueued = total_enq;
		e.fields.dequeued = total_deq;
		e.fields.lost = total_drop;
		e.fields.peak = OCC_W'(q_peak);
		e.last = last;
		expected_results = {expected_results, e};
	endfunction

	function automatic logic [HDL_W-1:0] take_oldest();
		logic [HDL_W-1:0] v;
		v = handle_store[q_head];
		q_head = (q_head + 1) % DEPTH_DEF;
		q_count--;
		return v;
	endfunction

	function automatic void predict_fifo(fifo_cmd_t c);
		logic [STAT_W-1:0] st;
		logic [HDL_W-1:0]  v;
		logic              done;
		int                n;
		st = ST_OK;
		done = 1'b0;
		case (c.op)
			OP_ENQ: begin
				if (q_stopped) begin
					st = ST_STOPPED;
				end else begin
					if (q_count >= usable_capacity()) begin
						total_drop++;
						if (policy_reg) begin
							st = ST_REJECT;
						end else begin
							v = take_oldest();
							st = ST_EVICTED;
						end
					end
					if (st != ST_REJECT) begin
						handle_store[q_tail] = c.handle;
						q_tail = (q_tail + 1) % DEPTH_DEF;
						q_count++;
						total_enq++;
						if (q_count > q_peak)
							q_peak = q_count;
					end
				end
			end
			OP_DEQ_ONE: begin
				if (q_stopped) begin
					st = ST_STOPPED;
				end else if (q_count == 0) begin
					st = ST_EMPTY;
				end else begin
					v = take_oldest();
					total_deq++;
					record_result(ST_OK, 1'b1, v, 1'b1);
					done = 1'b1;
				end
			end
			OP_DEQ_BAT: begin
				if (q_stopped) begin
					st = ST_STOPPED;
				end else if (q_count == 0) begin
					st = ST_EMPTY;
				end else begin
					n = (c.limit < MAX_BATCH_DEF) ? int'(c.limit) : MAX_BATCH_DEF;
					if (n > q_count)
						n = q_count;
					for (int k = 0; k < n; k++) begin
						v = take_oldest();
						total_deq++;
						record_result(ST_OK, 1'b1, v, k == n - 1);
					end
					done = (n != 0);
				end
			end
			OP_CLEAR: begin
				total_drop += TOT_W'(q_count);
				q_count = 0;
				q_head = q_tail;
			end
			OP_STOP: begin
				q_stopped = 1'b1;
			end
			OP_RST_STAT: begin
				total_enq = '0;
				total_deq = '0;
				total_drop = '0;
				q_peak = 0;
			end
			default: begin
			end
		endcase
		if (!done)
			record_result(st, 1'b0, '0, 1'b1);
	endfunction

	function automatic void check_field(string name, logic [TOT_W-1:0] want,
			logic [TOT_W-1:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			errors++;
		end
	endfunction

	// Inputs are predicted before outputs are checked, so a result always
	// finds the expectations of every command taken up to this edge.
	always @(posedge clk) begin
		fifo_result_t got;
		fifo_expect_t want;
		in_took = arst_n && s_tvalid && s_tready;
		out_took = arst_n && m_tvalid && m_tready;
		if (in_took)
			predict_fifo(sent_cmd);
		if (out_took) begin
			got = fifo_result_t'(m_tdata);
			if (expected_results.size() == 0) begin
				$error("unexpected result: status %0d handle %0h", got.status, got.handle);
				errors++;
			end else begin
				want = expected_results.pop_front();
				check_field("status", want.fields.status, got.status);
				check_field("data_valid", want.fields.valid, got.valid);
				check_field("returned_handle", want.fields.handle, got.handle);
				check_field("last_of_run", want.last, m_tlast);
				check_field("occupancy", want.fields.occ, got.occ);
				check_field("total_in", want.fields.enqueued, got.enqueued);
				check_field("total_out", want.fields.dequeued, got.dequeued);
				check_field("total_lost", want.fields.lost, got.lost);
				check_field("peak_occupancy", want.fields.peak, got.peak);
			end
		end
	end

	always @(negedge clk) begin
		fifo_cmd_t c;
		if (arst_n) begin
			if (s_tvalid && !in_took) begin
			end else if (send_gap > 0) begin
				s_tvalid <= 1'b0;
				send_gap--;
			end else if (pending_cmds.size() > 0) begin
				c = pending_cmds.pop_front();
				sent_cmd <= c;
				s_tdata <= S_DATA_W'({c.limit, c.handle, c.op});
				s_tvalid <= 1'b1;
				if ($urandom_range(0, 15) == 0)
					send_calm = !send_calm;
				send_gap = send_calm ? 0 : $urandom_range(0, 4);
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (arst_n) begin
			if (out_took) begin
				if ($urandom_range(0, 15) == 0)
					recv_calm = !recv_calm;
				recv_stall = recv_calm ? 0 : $urandom_range(0, 4);
			end else if (recv_stall > 0) begin
				recv_stall--;
			end
			m_tready <= (recv_stall == 0);
		end
	end

	function automatic void push_cmd(logic [OP_W-1:0] op, logic [HDL_W-1:0] handle,
			logic [LIMIT_W-1:0] limit);
		fifo_cmd_t c;
		c.op = op;
		c.handle = handle;
		c.limit = limit;
		pending_cmds = {pending_cmds, c};
	endfunction

	task automatic wait_drained();
		while (pending_cmds.size() != 0 || s_tvalid || expected_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// The queue model applies a capacity write only when the queue is empty.
	task automatic write_reg(reg_ix_t ix, int value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= ix;
		cfg_data <= CFG_D_W'(value);
		@(negedge clk);
		cfg_we <= 1'b0;
		if (ix == REG_CAPACITY) begin
			if (q_count == 0)
				cap_reg = value & ((1 << CAP_W) - 1);
		end else begin
			policy_reg = value[0];
		end
	endtask

	initial begin
		#6_000_000;
		$display("bounded_fifo_with_drop_policy regression: fail");
		$finish;
	end

	initial begin
		int   caps [PHASES];
		logic pols [PHASES];
		int   r;
		logic [OP_W-1:0]    op;
		logic [LIMIT_W-1:0] limit;

		caps = '{1, 3, 16, 2047, 0, 2};
		pols = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		push_cmd(OP_DEQ_ONE, '0, '0);
		push_cmd(OP_DEQ_BAT, '1, 5'd1);
		push_cmd(OP_DEQ_BAT, '0, '0);
		push_cmd(OP_ENQ, '0, '0);
		push_cmd(OP_ENQ, '1, '1);
		for (int i = 0; i < 3; i++)
			push_cmd(OP_ENQ, $urandom, '0);
		push_cmd(OP_DEQ_BAT, '0, '0);
		push_cmd(OP_DEQ_BAT, '0, 5'd2);
		push_cmd(OP_DEQ_ONE, '1, '1);
		push_cmd(OP_SPARE_6, '1, '1);
		push_cmd(OP_SPARE_7, $urandom, '1);
		push_cmd(OP_DEQ_BAT, '0, '1);
		push_cmd(OP_RST_STAT, '0, '0);
		push_cmd(OP_ENQ, $urandom, '0);
		push_cmd(OP_ENQ, $urandom, '0);
		push_cmd(OP_CLEAR, '0, '0);
		push_cmd(OP_DEQ_ONE, '0, '0);
		wait_drained();

		for (int p = 0; p < PHASES; p++) begin
			write_reg(REG_CAPACITY, caps[p]);
			write_reg(REG_POLICY, pols[p]);
			push_cmd(OP_CLEAR, '0, '0);
			wait_drained();
			write_reg(REG_CAPACITY, caps[p]);
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if (i == PHASE_ITEMS / 2)
					wait_drained();
				r = $urandom_range(0, 99);
				if (r < 55)
					op = OP_ENQ;
				else if (r < 70)
					op = OP_DEQ_ONE;
				else if (r < 88)
					op = OP_DEQ_BAT;
				else if (r < 92)
					op = OP_CLEAR;
				else if (r < 96)
					op = OP_RST_STAT;
				else if (r < 98)
					op = OP_SPARE_6;
				else
					op = OP_SPARE_7;
				if ($urandom_range(0, 7) == 0)
					limit = LIMIT_W'($urandom);
				else
					limit = LIMIT_W'($urandom_range(1, 4));
				push_cmd(op, $urandom, limit);
			end
			wait_drained();
		end

		for (int i = 0; i < 3; i++)
			push_cmd(OP_ENQ, $urandom, '0);
		push_cmd(OP_STOP, '0, '0);
		push_cmd(OP_ENQ, $urandom, '0);
		push_cmd(OP_DEQ_ONE, '0, '0);
		push_cmd(OP_DEQ_BAT, '0, 5'd4);
		push_cmd(OP_SPARE_6, '0, '0);
		push_cmd(OP_CLEAR, '0, '0);
		push_cmd(OP_RST_STAT, '0, '0);
		push_cmd(OP_ENQ, $urandom, '0);
		push_cmd(OP_DEQ_BAT, '0, 5'd2);

		wait_drained();
		repeat (16) @(posedge clk);
		if (errors == 0)
			$display("bounded_fifo_with_drop_policy regression: pass");
		else
			$display("bounded_fifo_with_drop_policy regression: fail");
		$finish;
	end

endmodule

[filelist.f]
hw/rtl/bfd_pkg.sv
hw/rtl/bfd_ctrl.sv
hw/rtl/bfd_datapath.sv
hw/rtl/bounded_fifo_with_drop_policy.sv
sim/tb.sv
